[design/bba_pkg.sv]
package bba_pkg;

    // Geometry of the used-bit map.
    localparam int MAX_BLOCKS = 1024;
    localparam int WORD_BITS  = 32;
    localparam int MAP_WORDS  = MAX_BLOCKS / WORD_BITS;

    localparam int BLK_W   = $clog2(MAX_BLOCKS);     // block index
    localparam int CNT_W   = BLK_W + 1;              // block counts up to MAX_BLOCKS
    localparam int WADDR_W = $clog2(MAP_WORDS);      // map word address
    localparam int BIT_W   = $clog2(WORD_BITS);      // bit inside a map word

    // The run scanner looks at one chunk of the map per cycle.
    localparam int CHUNK_BITS = 8;
    localparam int CHUNK_W    = $clog2(CHUNK_BITS);
    localparam int POS_W      = BLK_W - CHUNK_W;     // chunk position in the map
    localparam int SEL_W      = BIT_W - CHUNK_W;     // chunk inside a map word

    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] MAX_TOTAL = CNT_W'(MAX_BLOCKS);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_BLOCKS = 1'b1;

    typedef enum logic [1:0] {
        ACT_ALLOC_ONE = 2'd0,
        ACT_ALLOC_RUN = 2'd1,
        ACT_FREE      = 2'd2,
        ACT_INIT      = 2'd3
    } action_e;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_INVALID  = 2'd2
    } status_e;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accept;
        logic    scan_read;
        logic    scan_step;
        logic    mark_read;
        logic    mark_write;
        logic    free_read;
        logic    free_write;
        logic    init_write;
        logic    status_en;
        status_e status;
        logic    load_out;
    } bba_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        action_e action;
        logic    len_zero;
        logic    free_zero;
        logic    idx_range_err;
        logic    scan_hit;
        logic    scan_end;
        logic    mark_last;
        logic    free_bit_set;
        logic    init_last;
        logic    out_free;
    } bba_stat_t;

endpackage

[design/bba_ctrl.sv]
module bba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bba_pkg::bba_stat_t  stat,
    output bba_pkg::bba_cmd_t   cmd
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_DECODE  = 10'b00_0000_0010,
        S_SCAN_RD = 10'b00_0000_0100,
        S_SCAN    = 10'b00_0000_1000,
        S_MARK_RD = 10'b00_0001_0000,
        S_MARK_WR = 10'b00_0010_0000,
        S_FREE_RD = 10'b00_0100_0000,
        S_FREE_WR = 10'b00_1000_0000,
        S_INIT    = 10'b01_0000_0000,
        S_DONE    = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.action)
                    bba_pkg::ACT_ALLOC_ONE:
                    begin
                        if (stat.free_zero)
                        begin
                            cmd.status_en = 1'b1;
                            cmd.status    = bba_pkg::ST_NO_SPACE;
                            state_next    = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    bba_pkg::ACT_ALLOC_RUN:
                    begin
                        if (stat.len_zero)
                        begin
                            cmd.status_en = 1'b1;
                            cmd.status    = bba_pkg::ST_INVALID;
                            state_next    = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    bba_pkg::ACT_FREE:
                    begin
                        if (stat.idx_range_err)
                        begin
                            cmd.status_en = 1'b1;
                            cmd.status    = bba_pkg::ST_INVALID;
                            state_next    = S_DONE;
                        end
                        else
                        begin
                            state_next = S_FREE_RD;
                        end
                    end
                    bba_pkg::ACT_INIT:
                    begin
                        state_next = S_INIT;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                cmd.scan_read = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_hit)
                begin
                    state_next = S_MARK_RD;
                end
                else if (stat.scan_end)
                begin
                    cmd.status_en = 1'b1;
                    cmd.status    = bba_pkg::ST_NO_SPACE;
                    state_next    = S_DONE;
                end
            end
            S_MARK_RD:
            begin
                cmd.mark_read = 1'b1;
                state_next    = S_MARK_WR;
            end
            S_MARK_WR:
            begin
                cmd.mark_write = 1'b1;
                state_next     = stat.mark_last ? S_DONE : S_MARK_RD;
            end
            S_FREE_RD:
            begin
                cmd.free_read = 1'b1;
                state_next    = S_FREE_WR;
            end
            S_FREE_WR:
            begin
                if (stat.free_bit_set)
                begin
                    cmd.free_write = 1'b1;
                end
                else
                begin
                    cmd.status_en = 1'b1;
                    cmd.status    = bba_pkg::ST_INVALID;
                end
                state_next = S_DONE;
            end
            S_INIT:
            begin
                cmd.init_write = 1'b1;
                if (stat.init_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[design/bba_dp.sv]
module bba_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [bba_pkg::CNT_W-1:0]     cfg_wdata,
    input  bba_pkg::action_e              in_action,
    input  logic [bba_pkg::CNT_W-1:0]     in_run_length,
    input  logic [bba_pkg::BLK_W-1:0]     in_block_index,
    input  logic                          out_ready,
    output logic                          out_valid,
    output bba_pkg::status_e              out_status,
    output logic [bba_pkg::BLK_W-1:0]     out_start,
    output logic [bba_pkg::CNT_W-1:0]     out_free,
    output logic [bba_pkg::CNT_W-1:0]     out_used,
    input  bba_pkg::bba_cmd_t             cmd,
    output bba_pkg::bba_stat_t            stat
);

    localparam int WB = bba_pkg::WORD_BITS;
    localparam int CB = bba_pkg::CHUNK_BITS;

    // Configuration.
    logic [bba_pkg::CNT_W-1:0] cfg_total_reg;
    logic [bba_pkg::CNT_W-1:0] cfg_reserved_reg;
    logic [bba_pkg::CNT_W-1:0] eff_total;
    logic [bba_pkg::CNT_W-1:0] eff_reserved;

    // Request and scan state.
    bba_pkg::action_e            act_reg;
    logic [bba_pkg::CNT_W-1:0]   len_reg;
    logic [bba_pkg::BLK_W-1:0]   idx_reg;
    logic [bba_pkg::POS_W-1:0]   pos_reg;
    logic [bba_pkg::CNT_W-1:0]   run_reg;
    logic [bba_pkg::BLK_W-1:0]   end_reg;
    logic [bba_pkg::WADDR_W-1:0] word_cnt_reg;
    bba_pkg::status_e            res_status_reg;
    logic [bba_pkg::BLK_W-1:0]   res_start_reg;
    logic [bba_pkg::CNT_W-1:0]   free_total_reg;
    logic [bba_pkg::CNT_W-1:0]   used_total_reg;
    logic [bba_pkg::CNT_W-1:0]   free_total_next;
    logic [bba_pkg::CNT_W-1:0]   used_total_next;

    // Output register.
    logic                        out_valid_reg;
    bba_pkg::status_e            out_status_reg;
    logic [bba_pkg::BLK_W-1:0]   out_start_reg;
    logic [bba_pkg::CNT_W-1:0]   out_free_reg;
    logic [bba_pkg::CNT_W-1:0]   out_used_reg;

    // Map memory with one valid bit per word; a word never written reads as zero.
    logic [WB-1:0]                map_mem [bba_pkg::MAP_WORDS];
    logic [bba_pkg::MAP_WORDS-1:0] map_valid_reg;
    logic [WB-1:0]                rd_data_reg;
    logic                         rd_ok_reg;
    logic [WB-1:0]                map_word;
    logic                         mem_re;
    logic [bba_pkg::WADDR_W-1:0]  mem_raddr;
    logic                         mem_we;
    logic [bba_pkg::WADDR_W-1:0]  mem_waddr;
    logic [WB-1:0]                mem_wdata;

    // Scan, mark, free and init datapath signals.
    logic [bba_pkg::BLK_W-1:0]    scan_base;
    logic [CB-1:0]                scan_bits;
    logic [bba_pkg::CNT_W-1:0]    run_next;
    logic                         scan_hit;
    logic [bba_pkg::CHUNK_W-1:0]  hit_pos;
    logic                         scan_end;
    logic                         read_ahead;
    logic [bba_pkg::BLK_W-1:0]    hit_end;
    logic [bba_pkg::CNT_W-1:0]    hit_start;
    logic [WB-1:0]                mark_mask;
    logic [WB-1:0]                init_mask;
    logic [WB-1:0]                free_word;
    logic                         mark_last;
    logic                         init_last;
    logic                         take_commit;
    logic                         init_commit;
    logic [bba_pkg::CNT_W:0]      used_sum;

    assign eff_total    = (cfg_total_reg > bba_pkg::MAX_TOTAL) ? bba_pkg::MAX_TOTAL
                                                               : cfg_total_reg;
    assign eff_reserved = (cfg_reserved_reg > eff_total) ? eff_total : cfg_reserved_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_total_reg    <= bba_pkg::MAX_TOTAL;
            cfg_reserved_reg <= bba_pkg::CNT_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                bba_pkg::CFG_TOTAL_BLOCKS:    cfg_total_reg    <= cfg_wdata;
                bba_pkg::CFG_RESERVED_BLOCKS: cfg_reserved_reg <= cfg_wdata;
                default:                      cfg_total_reg    <= cfg_total_reg;
            endcase
        end
    end

    // Map memory port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= map_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_valid_reg <= '0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                map_valid_reg[mem_waddr] <= 1'b1;
            end
            if (mem_re)
            begin
                rd_ok_reg <= map_valid_reg[mem_raddr];
            end
        end
    end

    assign map_word = rd_ok_reg ? rd_data_reg : '0;

    // One chunk of the run search: a block counts as free only inside 1 .. total-1.
    assign scan_base = {pos_reg, {bba_pkg::CHUNK_W{1'b0}}};
    assign scan_bits = map_word[{pos_reg[bba_pkg::SEL_W-1:0],
                                 {bba_pkg::CHUNK_W{1'b0}}} +: CB];

    always_comb
    begin
        logic [bba_pkg::CNT_W-1:0] blk;
        logic                      usable;
        run_next = run_reg;
        scan_hit = 1'b0;
        hit_pos  = '0;
        for (int k = 0; k < CB; k++)
        begin
            blk    = {1'b0, scan_base} + bba_pkg::CNT_W'(k);
            usable = (blk != '0) && (blk < eff_total) && !scan_bits[k];
            if (!scan_hit)
            begin
                run_next = usable ? run_next + 1'b1 : '0;
                if (run_next == len_reg)
                begin
                    scan_hit = 1'b1;
                    hit_pos  = bba_pkg::CHUNK_W'(k);
                end
            end
        end
    end

    assign scan_end   = ({1'b0, scan_base} + bba_pkg::CNT_W'(CB)) >= eff_total;
    assign read_ahead = (pos_reg[bba_pkg::SEL_W-1:0] == {bba_pkg::SEL_W{1'b1}})
                        && !scan_hit && !scan_end;
    assign hit_end    = {pos_reg, hit_pos};
    assign hit_start  = {1'b0, hit_end} + bba_pkg::CNT_W'(1) - len_reg;

    // Word masks for marking a run and for the init sweep.
    always_comb
    begin
        logic [bba_pkg::BLK_W-1:0] blk;
        for (int b = 0; b < WB; b++)
        begin
            blk          = {word_cnt_reg, bba_pkg::BIT_W'(b)};
            mark_mask[b] = (blk >= res_start_reg) && (blk <= end_reg);
            init_mask[b] = ({1'b0, blk} < eff_reserved);
        end
    end

    always_comb
    begin
        free_word = map_word;
        free_word[idx_reg[bba_pkg::BIT_W-1:0]] = 1'b0;
    end

    assign mark_last   = (word_cnt_reg == end_reg[bba_pkg::BLK_W-1 -: bba_pkg::WADDR_W]);
    assign init_last   = (word_cnt_reg == {bba_pkg::WADDR_W{1'b1}});
    assign take_commit = cmd.mark_write && mark_last;
    assign init_commit = cmd.init_write && init_last;

    always_comb
    begin
        mem_re    = cmd.scan_read || (cmd.scan_step && read_ahead)
                    || cmd.mark_read || cmd.free_read;
        if (cmd.scan_read)
        begin
            mem_raddr = pos_reg[bba_pkg::POS_W-1 -: bba_pkg::WADDR_W];
        end
        else if (cmd.scan_step)
        begin
            mem_raddr = pos_reg[bba_pkg::POS_W-1 -: bba_pkg::WADDR_W] + 1'b1;
        end
        else if (cmd.mark_read)
        begin
            mem_raddr = word_cnt_reg;
        end
        else
        begin
            mem_raddr = idx_reg[bba_pkg::BLK_W-1 -: bba_pkg::WADDR_W];
        end
        mem_we    = cmd.mark_write || cmd.free_write || cmd.init_write;
        mem_waddr = cmd.free_write ? idx_reg[bba_pkg::BLK_W-1 -: bba_pkg::WADDR_W]
                                   : word_cnt_reg;
        if (cmd.mark_write)
        begin
            mem_wdata = map_word | mark_mask;
        end
        else if (cmd.free_write)
        begin
            mem_wdata = free_word;
        end
        else
        begin
            mem_wdata = init_mask;
        end
    end

    // Block counters, saturating at both ends.
    assign used_sum = {1'b0, used_total_reg} + {1'b0, len_reg};

    always_comb
    begin
        free_total_next = free_total_reg;
        used_total_next = used_total_reg;
        if (take_commit)
        begin
            free_total_next = (free_total_reg > len_reg) ? free_total_reg - len_reg : '0;
            used_total_next = (used_sum > {1'b0, bba_pkg::CNT_MAX})
                              ? bba_pkg::CNT_MAX : used_sum[bba_pkg::CNT_W-1:0];
        end
        else if (cmd.free_write)
        begin
            free_total_next = (free_total_reg == bba_pkg::CNT_MAX)
                              ? bba_pkg::CNT_MAX : free_total_reg + 1'b1;
            used_total_next = (used_total_reg != '0) ? used_total_reg - 1'b1 : '0;
        end
        else if (init_commit)
        begin
            free_total_next = eff_total - eff_reserved;
            used_total_next = eff_reserved;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_total_reg <= '0;
            used_total_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            free_total_reg <= free_total_next;
            used_total_reg <= used_total_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            act_reg        <= in_action;
            len_reg        <= (in_action == bba_pkg::ACT_ALLOC_ONE)
                              ? bba_pkg::CNT_W'(1) : in_run_length;
            idx_reg        <= in_block_index;
            pos_reg        <= '0;
            run_reg        <= '0;
            word_cnt_reg   <= '0;
            res_status_reg <= bba_pkg::ST_OK;
            res_start_reg  <= '0;
        end
        else
        begin
            if (cmd.scan_step)
            begin
                pos_reg <= pos_reg + 1'b1;
                run_reg <= run_next;
                if (scan_hit)
                begin
                    end_reg       <= hit_end;
                    res_start_reg <= hit_start[bba_pkg::BLK_W-1:0];
                    word_cnt_reg  <= hit_start[bba_pkg::BLK_W-1 -: bba_pkg::WADDR_W];
                end
            end
            if ((cmd.mark_write && !mark_last) || cmd.init_write)
            begin
                word_cnt_reg <= word_cnt_reg + 1'b1;
            end
            if (cmd.status_en)
            begin
                res_status_reg <= cmd.status;
            end
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_start_reg  <= res_start_reg;
            out_free_reg   <= free_total_reg;
            out_used_reg   <= used_total_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_start  = out_start_reg;
    assign out_free   = out_free_reg;
    assign out_used   = out_used_reg;

    assign stat.action        = act_reg;
    assign stat.len_zero      = (len_reg == '0);
    assign stat.free_zero     = (free_total_reg == '0);
    assign stat.idx_range_err = ({1'b0, idx_reg} >= eff_total);
    assign stat.scan_hit      = scan_hit;
    assign stat.scan_end      = scan_end;
    assign stat.mark_last     = mark_last;
    assign stat.free_bit_set  = map_word[idx_reg[bba_pkg::BIT_W-1:0]];
    assign stat.init_last     = init_last;
    assign stat.out_free      = !out_valid_reg || out_ready;

endmodule

[design/bitmap_block_allocator_top.sv]
// Channel   Direction  Words carried
// --------  ---------  -------------------------------------------------------------
// cfg       in         register writes: total_blocks (index 0), reserved_blocks (1)
// s_axis    in         one request per word: action, run length, block to free
// m_axis    out        one reply per request: status, first block, free and used counts
//
// Requests are handled one at a time: accept, decode and reply load plus the work. An
// alloc reads a map word, searches one 8-bit chunk per cycle over the map, then reads
// and writes each map word the granted run touches. A free reads one map word and writes it
// if the block was used, an init writes every map word, and a decode refusal goes to reply
// load. Reset clears both counters, the reply valid flag and the map; init marks reserved
// blocks. A stalled m_axis holds its reply while the next request runs; that reply waits to load.
module bitmap_block_allocator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write port.
    input  logic                          cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [bba_pkg::CNT_W-1:0]     cfg_wdata,
    // Request stream.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,   // run_length[10:0], block_index[20:11]
    input  logic [1:0]                    s_axis_tuser,   // action[1:0]
    // Reply stream.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,   // first_block[9:0], free_count[20:10],
                                                          // used_count[31:21]
    output logic [1:0]                    m_axis_tuser    // status[1:0]
);

    bba_pkg::bba_cmd_t         cmd;
    bba_pkg::bba_stat_t        stat;
    bba_pkg::status_e          out_status;
    logic [bba_pkg::BLK_W-1:0] out_start;
    logic [bba_pkg::CNT_W-1:0] out_free;
    logic [bba_pkg::CNT_W-1:0] out_used;

    // The controller sequences each request; it sees only the request valid and the status flags.
    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath owns the map memory, the counters and the reply register.
    bba_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .in_action      (bba_pkg::action_e'(s_axis_tuser)),
        .in_run_length  (s_axis_tdata[10:0]),
        .in_block_index (s_axis_tdata[20:11]),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .out_status     (out_status),
        .out_start      (out_start),
        .out_free       (out_free),
        .out_used       (out_used),
        .cmd            (cmd),
        .stat           (stat)
    );

    assign m_axis_tdata = {out_used, out_free, out_start};
    assign m_axis_tuser = out_status;

endmodule

[design/bba_checker.sv]
module bba_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [31:0]                   m_axis_tdata,
    input logic [1:0]                    m_axis_tuser
);

    // A stalled reply keeps its contents.
    a_reply_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("reply changed while stalled");

    // A refused or failed request grants no block.
    a_fail_no_start: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != bba_pkg::ST_OK) |->
            (m_axis_tdata[9:0] == 10'd0))
        else $error("failed request reports a start block");

    // Requests are taken one at a time: ready drops right after an accept.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request accepted while one is in progress");

    // A new reply word appears just as the block returns to taking requests.
    a_reply_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("reply raised while a request is still in progress");

endmodule

bind bitmap_block_allocator_top bba_checker u_bba_checker (.*);

[tb/bitmap_block_allocator_checker.sv]
module bitmap_block_allocator_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [bba_pkg::CNT_W-1:0]     cfg_wdata,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,   // run_length[10:0], block_index[20:11]
    input  logic [1:0]                    s_axis_tuser,   // action[1:0]
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [31:0]                   m_axis_tdata,   // first_block[9:0], free_count[20:10],
                                                          // used_count[31:21]
    input  logic [1:0]                    m_axis_tuser,   // status[1:0]
    output int                            errors,
    output int                            pending,
    output int                            granted_cnt,
    output int                            no_space_cnt,
    output int                            refused_cnt
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_CEIL = int'(bba_pkg::CNT_MAX);

    typedef struct packed {
        bba_pkg::status_e          status;
        logic [bba_pkg::BLK_W-1:0] start;
        logic [bba_pkg::CNT_W-1:0] free_cnt;
        logic [bba_pkg::CNT_W-1:0] used_cnt;
    } reply_t;

    // Shadow of the allocator: one used bit per block plus the two counters.
    bit     blk_used [0:bba_pkg::MAX_BLOCKS-1];
    int     free_blocks;
    int     used_blocks;
    int     total_reg;
    int     reserved_reg;
    int     reply_no;
    reply_t due_reply;
    reply_t owed_replies [$];

    task automatic report_mismatch(input string msg);
        errors++;
        $display("%0t: reply %0d: %s", $time, reply_no, msg);
    endtask

    function automatic void take_blocks(input int n);
        free_blocks = (free_blocks > n) ? free_blocks - n : 0;
        used_blocks = (used_blocks + n > COUNT_CEIL) ? COUNT_CEIL : used_blocks + n;
    endfunction

    // Applies one request to the shadow state and returns the reply it must produce.
    function automatic reply_t serve_request(input bba_pkg::action_e act, input int len,
                                             input int idx);
        int     lim;
        int     run;
        int     keep;
        int     b;
        int     k;
        bit     found;
        reply_t rep;
        lim        = (total_reg > bba_pkg::MAX_BLOCKS) ? bba_pkg::MAX_BLOCKS : total_reg;
        found      = 1'b0;
        rep.status = bba_pkg::ST_OK;
        rep.start  = '0;
        case (act)
            bba_pkg::ACT_ALLOC_ONE:
            begin
                rep.status = bba_pkg::ST_NO_SPACE;
                if (free_blocks != 0)
                begin
                    for (b = 1; b < lim && !found; b++)
                    begin
                        if (!blk_used[b])
                        begin
                            blk_used[b] = 1'b1;
                            take_blocks(1);
                            rep.start  = bba_pkg::BLK_W'(b);
                            rep.status = bba_pkg::ST_OK;
                            found      = 1'b1;
                        end
                    end
                end
            end
            bba_pkg::ACT_ALLOC_RUN:
            begin
                if (len == 0)
                    rep.status = bba_pkg::ST_INVALID;
                else
                begin
                    rep.status = bba_pkg::ST_NO_SPACE;
                    run        = 0;
                    for (b = 1; b < lim && !found; b++)
                    begin
                        run = blk_used[b] ? 0 : run + 1;
                        if (run == len)
                        begin
                            for (k = b + 1 - len; k <= b; k++)
                                blk_used[k] = 1'b1;
                            take_blocks(len);
                            rep.start  = bba_pkg::BLK_W'(b + 1 - len);
                            rep.status = bba_pkg::ST_OK;
                            found      = 1'b1;
                        end
                    end
                end
            end
            bba_pkg::ACT_FREE:
            begin
                if (idx >= lim || !blk_used[idx])
                    rep.status = bba_pkg::ST_INVALID;
                else
                begin
                    blk_used[idx] = 1'b0;
                    free_blocks   = (free_blocks >= COUNT_CEIL) ? COUNT_CEIL : free_blocks + 1;
                    used_blocks   = (used_blocks > 0) ? used_blocks - 1 : 0;
                end
            end
            default:
            begin
                keep = (reserved_reg > lim) ? lim : reserved_reg;
                for (b = 0; b < bba_pkg::MAX_BLOCKS; b++)
                    blk_used[b] = (b < keep);
                used_blocks = keep;
                free_blocks = lim - keep;
            end
        endcase
        rep.free_cnt = bba_pkg::CNT_W'(free_blocks);
        rep.used_cnt = bba_pkg::CNT_W'(used_blocks);
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < bba_pkg::MAX_BLOCKS; b++)
                blk_used[b] = 1'b0;
            free_blocks  = 0;
            used_blocks  = 0;
            total_reg    = bba_pkg::MAX_BLOCKS;
            reserved_reg = 1;
            reply_no     = 0;
            errors       = 0;
            granted_cnt  = 0;
            no_space_cnt = 0;
            refused_cnt  = 0;
            owed_replies.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == bba_pkg::CFG_TOTAL_BLOCKS)
                    total_reg = int'(cfg_wdata);
                else if (cfg_addr == bba_pkg::CFG_RESERVED_BLOCKS)
                    reserved_reg = int'(cfg_wdata);
            end

            // The reply leaving at this edge belongs to an earlier request, so it is
            // compared before a request accepted at the same edge is queued.
            if (m_axis_tvalid && m_axis_tready)
            begin
                reply_no++;
                if (owed_replies.size() == 0)
                    report_mismatch("reply word with no request outstanding");
                else
                begin
                    due_reply = owed_replies.pop_front();
                    if (m_axis_tuser != due_reply.status)
                        report_mismatch($sformatf("status expected %0d, got %0d",
                                                  due_reply.status, m_axis_tuser));
                    if (m_axis_tdata[9:0] != due_reply.start)
                        report_mismatch($sformatf("first_block expected %0d, got %0d",
                                                  due_reply.start, m_axis_tdata[9:0]));
                    if (m_axis_tdata[20:10] != due_reply.free_cnt)
                        report_mismatch($sformatf("free_count expected %0d, got %0d",
                                                  due_reply.free_cnt, m_axis_tdata[20:10]));
                    if (m_axis_tdata[31:21] != due_reply.used_cnt)
                        report_mismatch($sformatf("used_count expected %0d, got %0d",
                                                  due_reply.used_cnt, m_axis_tdata[31:21]));
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                due_reply = serve_request(bba_pkg::action_e'(s_axis_tuser),
                                          int'(s_axis_tdata[10:0]),
                                          int'(s_axis_tdata[20:11]));
                case (due_reply.status)
                    bba_pkg::ST_OK:       granted_cnt++;
                    bba_pkg::ST_NO_SPACE: no_space_cnt++;
                    default:              refused_cnt++;
                endcase
                owed_replies.push_back(due_reply);
            end

            pending <= owed_replies.size();
        end
    end

endmodule

[tb/bitmap_block_allocator_top_test.sv]
module bitmap_block_allocator_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    // The slowest request is an alloc whose search covers the whole map and then
    // marks every map word. A quiet stretch as long as QUIET_LIMIT therefore means
    // the block has hung.
    localparam int QUIET_LIMIT  = 4000;
    // After the last reply the block gets this many cycles to show a stray word.
    localparam int DRAIN_CYCLES = 300;
    localparam int PHASES       = 12;
    localparam int RANDOM_ITEMS = 96;

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          cfg_we        = 1'b0;
    logic [bba_pkg::CFG_IDX_W-1:0] cfg_addr      = bba_pkg::CFG_TOTAL_BLOCKS;
    logic [bba_pkg::CNT_W-1:0]     cfg_wdata     = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [23:0]                   s_axis_tdata  = '0;   // run_length[10:0], block_index[20:11]
    logic [1:0]                    s_axis_tuser  = '0;   // action[1:0]
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [31:0]                   m_axis_tdata;         // first_block[9:0], free_count[20:10],
                                                         // used_count[31:21]
    logic [1:0]                    m_axis_tuser;         // status[1:0]

    int errors;
    int pending;
    int granted_cnt;
    int no_space_cnt;
    int refused_cnt;

    // Chance, in percent, that the sender inserts an idle cycle before a word and
    // that the receiver holds tready low in a given cycle.
    int idle_pct  = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int sent_by_action [4] = '{0, 0, 0, 0};

    // Each phase programs one size setting and one idling pattern. The settings
    // include the extremes: a single block, no blocks at all, both registers at
    // their all-ones value (capped to the map size), and more reserved blocks than
    // managed ones. Phase 8 skips the opening init, so the new total takes effect
    // for searches while the counters still reflect the previous setting.
    int plan_total [0:PHASES-1]    = '{1024, 64, 40, 1, 0, 2047, 200, 33, 100, 1024, 48, 512};
    int plan_reserved [0:PHASES-1] = '{1, 4, 1024, 0, 5, 2047, 0, 2, 10, 0, 1, 100};
    bit plan_init [0:PHASES-1]     = '{0, 1, 1, 1, 1, 1, 1, 1, 0, 1, 1, 1};

    bitmap_block_allocator_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    bitmap_block_allocator_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .errors        (errors),
        .pending       (pending),
        .granted_cnt   (granted_cnt),
        .no_space_cnt  (no_space_cnt),
        .refused_cnt   (refused_cnt)
    );

    always #5 clk = ~clk;

    // The receiver decides afresh every cycle whether it takes a reply word.
    always @(posedge clk)
        m_axis_tready <= rst_n && ($urandom_range(0, 99) >= stall_pct);

    // Watchdog: any word moving on either stream restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no word moved for %0d cycles, %0d replies outstanding",
                     QUIET_LIMIT, pending);
            $display("bitmap_block_allocator_top_test: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offers one request word and returns right after the edge that accepts it.
    // tvalid stays high on return, so back-to-back words need no extra edge; it
    // is lowered only for an idle cycle or at the end of a phase.
    task automatic send_word(input bba_pkg::action_e act, input int len, input int idx);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {3'b000, 10'(idx), 11'(len)};
        sent_by_action[act]++;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    initial
    begin
        int               p;
        int               n;
        int               pick;
        int               lim;
        int               len;
        int               idx;
        bba_pkg::action_e act;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (p = 0; p < PHASES; p++)
        begin
            // The block is idle here: either fresh out of reset or every reply of
            // the previous phase has been taken.
            cfg_we    <= 1'b1;
            cfg_addr  <= bba_pkg::CFG_TOTAL_BLOCKS;
            cfg_wdata <= bba_pkg::CNT_W'(plan_total[p]);
            @(posedge clk);
            cfg_addr  <= bba_pkg::CFG_RESERVED_BLOCKS;
            cfg_wdata <= bba_pkg::CNT_W'(plan_reserved[p]);
            @(posedge clk);
            cfg_we    <= 1'b0;

            // Idling patterns rotate: none, the sender idling at a 67 percent chance, the
            // receiver stalling at a 67 percent chance, and both at a light rate.
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 67; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 67; end
                default: begin idle_pct = 9;  stall_pct = 9;  end
            endcase
            lim = (plan_total[p] > bba_pkg::MAX_BLOCKS) ? bba_pkg::MAX_BLOCKS : plan_total[p];

            if (p == 0)
            begin
                // Before any init the counters are zero: alloc one sees no space,
                // nothing can be freed, yet a run is still found in the clear map.
                send_word(bba_pkg::ACT_ALLOC_ONE, 0, 0);
                send_word(bba_pkg::ACT_FREE, 0, 0);
                send_word(bba_pkg::ACT_FREE, 0, 1023);
                send_word(bba_pkg::ACT_ALLOC_RUN, 0, 0);
                send_word(bba_pkg::ACT_ALLOC_RUN, 3, 0);
                send_word(bba_pkg::ACT_INIT, 0, 0);
                send_word(bba_pkg::ACT_ALLOC_ONE, 0, 0);
                // A run longer than what is left, then one ending on the last block.
                send_word(bba_pkg::ACT_ALLOC_RUN, 1024, 0);
                send_word(bba_pkg::ACT_ALLOC_RUN, 1022, 0);
                send_word(bba_pkg::ACT_ALLOC_ONE, 0, 0);
                // Free the last block twice; the second is refused.
                send_word(bba_pkg::ACT_FREE, 0, 1023);
                send_word(bba_pkg::ACT_FREE, 0, 1023);
                send_word(bba_pkg::ACT_ALLOC_RUN, 1, 0);
                // Block 0 may be freed, but alloc one never hands it out.
                send_word(bba_pkg::ACT_FREE, 0, 0);
                send_word(bba_pkg::ACT_ALLOC_ONE, 0, 0);
                send_word(bba_pkg::ACT_FREE, 0, 512);
                send_word(bba_pkg::ACT_ALLOC_ONE, 0, 0);
                send_word(bba_pkg::ACT_ALLOC_RUN, 2047, 0);
                send_word(bba_pkg::ACT_INIT, 0, 0);
                send_word(bba_pkg::ACT_ALLOC_RUN, 1023, 0);
                send_word(bba_pkg::ACT_FREE, 0, 1023);
                send_word(bba_pkg::ACT_ALLOC_RUN, 1, 0);
            end

            if (plan_init[p])
                send_word(bba_pkg::ACT_INIT, 0, 0);

            // Mostly allocations and frees on a live map, with an occasional init.
            // Short runs keep the map fragmented; long ones, zero lengths, lengths
            // past the map and frees outside the range or of free blocks are mixed in.
            for (n = 0; n < RANDOM_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    act = bba_pkg::ACT_INIT;
                else if (pick < 40)
                    act = bba_pkg::ACT_ALLOC_ONE;
                else if (pick < 65)
                    act = bba_pkg::ACT_ALLOC_RUN;
                else
                    act = bba_pkg::ACT_FREE;

                pick = $urandom_range(0, 99);
                if (pick < 70)
                    len = $urandom_range(1, 8);
                else if (pick < 90)
                    len = $urandom_range(1, (lim > 1) ? lim : 1);
                else if (pick < 95)
                    len = 0;
                else
                    len = $urandom_range(0, 2047);

                if (lim > 0 && $urandom_range(0, 99) < 85)
                    idx = $urandom_range(0, lim - 1);
                else
                    idx = $urandom_range(0, 1023);

                send_word(act, len, idx);
            end

            // Let every reply of the phase arrive before the registers change.
            // pending is a registered copy of the queue size, so it is read after waiting on an edge.
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while (pending != 0);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests: %0d alloc one, %0d alloc run, %0d free, %0d init.",
                 sent_by_action[0] + sent_by_action[1] + sent_by_action[2] + sent_by_action[3],
                 sent_by_action[bba_pkg::ACT_ALLOC_ONE], sent_by_action[bba_pkg::ACT_ALLOC_RUN],
                 sent_by_action[bba_pkg::ACT_FREE], sent_by_action[bba_pkg::ACT_INIT]);
        $display("%0d size settings; %0d ok, %0d without space, %0d refused; %0d errors.",
                 PHASES, granted_cnt, no_space_cnt, refused_cnt, errors);
        if (errors == 0 && pending == 0)
            $display("bitmap_block_allocator_top_test: PASS");
        else
            $display("bitmap_block_allocator_top_test: FAIL");
        $finish;
    end

endmodule
